>>> hw/rtl/rast_pkg.sv
// Shared codes for the ray versus padded box slab test.
// Holds the register indexes, normal axis codes and the control struct; no dependencies.
`timescale 1ns / 1ps

package rast_pkg;

    localparam logic [1:0] REG_PAD_X = 2'd0;
    localparam logic [1:0] REG_PAD_Y = 2'd1;
    localparam logic [1:0] REG_PAD_Z = 2'd2;

    localparam logic [1:0] AXIS_NONE = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd1;
    localparam logic [1:0] AXIS_Y    = 2'd2;
    localparam logic [1:0] AXIS_Z    = 2'd3;

    typedef struct packed {
        logic       hit;
        logic [1:0] normal_axis;
        logic       normal_positive;
    } rast_ctl_t;

endpackage

>>> hw/rtl/ray_aabb_slab_test_core.sv
// Top level of the ray versus padded axis-aligned box slab test.
// Depends on rast_pkg, rast_slab_div, rast_select and rast_hitpos.
`timescale 1ns / 1ps
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   -------------------------------------------------
//  input     in_valid / in_ready       origin, dir, box_center, box_size per axis
//  output    out_valid / out_ready     hit, hit_time, hit_pos_x/y/z, normal_axis/positive
//  config    psel/penable/pwrite       pad_x, pad_y, pad_z at byte addresses 0, 4, 8
//
// One item enters per cycle while the output is not stalled. The six slab dividers
// resolve one quotient bit per stage.
// Reset clears the valid bits and the padding registers; payload registers are not reset.
// The whole pipeline advances whenever the output register is empty or being taken, so a
// stall at the output freezes every stage in place and nothing is lost or repeated.

module ray_aabb_slab_test_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int DATA_W     = (COORD_WIDTH - 1 > 32) ? 64 : 32,
    localparam int ADDR_SH    = (COORD_WIDTH - 1 > 32) ? 3 : 2,
    localparam int PADDR_W    = ADDR_SH + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    input  logic signed [COORD_WIDTH-1:0] box_center_x,
    input  logic signed [COORD_WIDTH-1:0] box_center_y,
    input  logic signed [COORD_WIDTH-1:0] box_center_z,
    input  logic [COORD_WIDTH-2:0]        box_size_x,
    input  logic [COORD_WIDTH-2:0]        box_size_y,
    input  logic [COORD_WIDTH-2:0]        box_size_z,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [COORD_WIDTH-2:0]        hit_time,
    output logic signed [COORD_WIDTH-1:0] hit_pos_x,
    output logic signed [COORD_WIDTH-1:0] hit_pos_y,
    output logic signed [COORD_WIDTH-1:0] hit_pos_z,
    output logic [1:0]                    normal_axis,
    output logic                          normal_positive
);
    import rast_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int NW    = W + 3;
    localparam int DEPTH = W + 6;
    localparam int DLEN  = W + 4;

    // ---------------------------------------------------------------
    // Configuration registers. Writes beyond the register list are dropped.
    // ---------------------------------------------------------------
    logic [W-2:0] pad_reg [3];
    logic [1:0]   cfg_idx;

    assign cfg_idx = paddr[ADDR_SH+1:ADDR_SH];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg[0] <= '0;
            pad_reg[1] <= '0;
            pad_reg[2] <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                REG_PAD_X: pad_reg[0] <= pwdata[W-2:0];
                REG_PAD_Y: pad_reg[1] <= pwdata[W-2:0];
                REG_PAD_Z: pad_reg[2] <= pwdata[W-2:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PAD_X: prdata = {{(DATA_W-W+1){1'b0}}, pad_reg[0]};
            REG_PAD_Y: prdata = {{(DATA_W-W+1){1'b0}}, pad_reg[1]};
            REG_PAD_Z: prdata = {{(DATA_W-W+1){1'b0}}, pad_reg[2]};
            default:   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline control: every stage moves together.
    // ---------------------------------------------------------------
    logic v_reg [DEPTH];
    logic adv;

    assign adv       = !v_reg[DEPTH-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // ---------------------------------------------------------------
    // Front stage: slab numerators d - e and d + e with d = 2*(center - origin)
    // and e = size + 2*pad, split into magnitude and sign for the dividers.
    // ---------------------------------------------------------------
    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];
    logic signed [W-1:0] ctr [3];
    logic [W-2:0]        sz  [3];

    assign org = '{origin_x, origin_y, origin_z};
    assign dir = '{dir_x, dir_y, dir_z};
    assign ctr = '{box_center_x, box_center_y, box_center_z};
    assign sz  = '{box_size_x, box_size_y, box_size_z};

    logic [NW-1:0] mag1_next [3];
    logic [NW-1:0] mag2_next [3];
    logic          neg1_next [3];
    logic          neg2_next [3];
    logic [W:0]    den_next  [3];

    always_comb
    begin
        logic signed [W:0]    diff;
        logic [W:0]           e;
        logic [NW-1:0]        n1;
        logic [NW-1:0]        n2;
        logic [NW-1:0]        d_ext;
        logic [W-1:0]         u;
        for (int ax = 0; ax < 3; ax++)
        begin
            diff  = {ctr[ax][W-1], ctr[ax]} - {org[ax][W-1], org[ax]};
            d_ext = {diff[W], diff, 1'b0};
            e     = {2'b00, sz[ax]} + {1'b0, pad_reg[ax], 1'b0};
            n1    = d_ext - {2'b00, e};
            n2    = d_ext + {2'b00, e};
            neg1_next[ax] = n1[NW-1];
            neg2_next[ax] = n2[NW-1];
            mag1_next[ax] = n1[NW-1] ? (~n1 + 1'b1) : n1;
            mag2_next[ax] = n2[NW-1] ? (~n2 + 1'b1) : n2;
            u             = dir[ax];
            den_next[ax]  = {(u[W-1] ? (~u + 1'b1) : u), 1'b0};
        end
    end

    logic [NW-1:0] mag1_reg [3];
    logic [NW-1:0] mag2_reg [3];
    logic          neg1_reg [3];
    logic          neg2_reg [3];
    logic [W:0]    den_reg  [3];
    logic          dneg_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg <= mag1_next;
            mag2_reg <= mag2_next;
            neg1_reg <= neg1_next;
            neg2_reg <= neg2_next;
            den_reg  <= den_next;
            for (int ax = 0; ax < 3; ax++)
                dneg_reg[ax] <= dir[ax][W-1];
        end
    end

    // Origin and direction ride along until the hit point is formed.
    logic signed [W-1:0] dlo_reg [DLEN][3];
    logic signed [W-1:0] dld_reg [DLEN][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dlo_reg[0] <= org;
            dld_reg[0] <= dir;
            for (int k = 1; k < DLEN; k++)
            begin
                dlo_reg[k] <= dlo_reg[k-1];
                dld_reg[k] <= dld_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Six slab dividers, two per axis.
    // ---------------------------------------------------------------
    logic signed [W-1:0] t_a [3];
    logic signed [W-1:0] t_b [3];
    logic                sel_dneg [3];

    for (genvar ax = 0; ax < 3; ax++)
    begin : g_axis
        rast_slab_div #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_div_near (
            .clk      (clk),
            .en       (adv),
            .num_mag  (mag1_reg[ax]),
            .num_neg  (neg1_reg[ax]),
            .num_zero (mag1_reg[ax] == '0),
            .den      (den_reg[ax]),
            .den_neg  (dneg_reg[ax]),
            .den_zero (den_reg[ax] == '0),
            .t        (t_a[ax])
        );

        rast_slab_div #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_div_far (
            .clk      (clk),
            .en       (adv),
            .num_mag  (mag2_reg[ax]),
            .num_neg  (neg2_reg[ax]),
            .num_zero (mag2_reg[ax] == '0),
            .den      (den_reg[ax]),
            .den_neg  (dneg_reg[ax]),
            .den_zero (den_reg[ax] == '0),
            .t        (t_b[ax])
        );

        assign sel_dneg[ax] = dld_reg[W][ax][W-1];
    end

    // ---------------------------------------------------------------
    // Entry and exit selection, then the hit point and output register.
    // ---------------------------------------------------------------
    rast_ctl_t    sel_ctl;
    logic [W-2:0] sel_t;

    rast_select #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_select (
        .clk     (clk),
        .en      (adv),
        .t_a     (t_a),
        .t_b     (t_b),
        .dir_neg (sel_dneg),
        .ctl     (sel_ctl),
        .t_hit   (sel_t)
    );

    logic signed [W-1:0] pos [3];

    rast_hitpos #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_hitpos (
        .clk             (clk),
        .en              (adv),
        .ctl             (sel_ctl),
        .t_hit           (sel_t),
        .org             (dlo_reg[DLEN-1]),
        .dir             (dld_reg[DLEN-1]),
        .hit             (hit),
        .hit_time        (hit_time),
        .hit_pos         (pos),
        .normal_axis     (normal_axis),
        .normal_positive (normal_positive)
    );

    assign hit_pos_x = pos[0];
    assign hit_pos_y = pos[1];
    assign hit_pos_z = pos[2];

endmodule

>>> hw/rtl/rast_slab_div.sv
// Pipelined restoring divider for one slab parameter, one quotient bit per stage.
// Depends on no package; instantiated by the top level.
`timescale 1ns / 1ps

module rast_slab_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [COORD_WIDTH+2:0]        num_mag,
    input  logic                          num_neg,
    input  logic                          num_zero,
    input  logic [COORD_WIDTH:0]          den,
    input  logic                          den_neg,
    input  logic                          den_zero,
    output logic signed [COORD_WIDTH-1:0] t
);
    localparam int W  = COORD_WIDTH;
    localparam int NW = W + 3;
    localparam int AW = NW + FRAC_BITS;
    localparam int RW = (AW > 2 * W) ? AW : 2 * W;

    logic [RW-1:0] r_reg    [W];
    logic [W-2:0]  q_reg    [W];
    logic [W:0]    b_reg    [W];
    logic          sat_reg  [W];
    logic          neg_reg  [W];
    logic          nneg_reg [W];
    logic          dz_reg   [W];
    logic          nz_reg   [W];

    logic [RW-1:0] a_ext;
    logic [RW-1:0] b_top;

    assign a_ext = RW'(num_mag) << FRAC_BITS;
    assign b_top = RW'(den) << (W - 1);

    // The first stage only decides whether the quotient overflows its range.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= a_ext;
            sat_reg[0]  <= (a_ext >= b_top);
            q_reg[0]    <= '0;
            b_reg[0]    <= den;
            neg_reg[0]  <= num_neg ^ den_neg;
            nneg_reg[0] <= num_neg;
            dz_reg[0]   <= den_zero;
            nz_reg[0]   <= num_zero;
        end
    end

    for (genvar k = 1; k < W; k++)
    begin : g_stage
        localparam int SH = W - 1 - k;
        logic [RW-1:0] cmp;
        logic          ge;
        logic [W-2:0]  qbit;

        assign cmp  = RW'(b_reg[k-1]) << SH;
        assign ge   = (r_reg[k-1] >= cmp);
        assign qbit = {{(W-2){1'b0}}, ge} << SH;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]     <= ge ? (r_reg[k-1] - cmp) : r_reg[k-1];
                q_reg[k]     <= q_reg[k-1] | qbit;
                b_reg[k]     <= b_reg[k-1];
                sat_reg[k]   <= sat_reg[k-1];
                neg_reg[k]   <= neg_reg[k-1];
                nneg_reg[k]  <= nneg_reg[k-1];
                dz_reg[k]    <= dz_reg[k-1];
                nz_reg[k]    <= nz_reg[k-1];
            end
        end
    end

    logic signed [W-1:0] tmax_c;
    logic signed [W-1:0] qs;

    assign tmax_c = {1'b0, {(W-1){1'b1}}};
    assign qs     = sat_reg[W-1] ? tmax_c : {1'b0, q_reg[W-1]};

    // A zero direction gives the saturated limit on the numerator's side, or zero when the numerator is also zero.
    always_comb
    begin
        if (dz_reg[W-1])
        begin
            if (nz_reg[W-1])
                t = '0;
            else
                t = nneg_reg[W-1] ? -tmax_c : tmax_c;
        end
        else
        begin
            t = neg_reg[W-1] ? -qs : qs;
        end
    end

endmodule

>>> hw/rtl/rast_select.sv
// Slab reduction: per-axis ordering, overall entry and exit, and the hit decision.
// Depends on rast_pkg; instantiated by the top level.
`timescale 1ns / 1ps

module rast_select #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] t_a [3],
    input  logic signed [COORD_WIDTH-1:0] t_b [3],
    input  logic                          dir_neg [3],
    output rast_pkg::rast_ctl_t           ctl,
    output logic [COORD_WIDTH-2:0]        t_hit
);
    import rast_pkg::*;

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] lo_reg [3];
    logic signed [W-1:0] hi_reg [3];
    logic                dna_reg [3];

    logic signed [W-1:0] near_reg [3];
    logic signed [W-1:0] tmin_reg;
    logic signed [W-1:0] tmax_reg;
    logic                dnb_reg [3];

    logic signed [W-1:0] tmin_next;
    logic signed [W-1:0] tmax_next;
    rast_ctl_t           ctl_next;
    logic [W-2:0]        t_next;
    rast_ctl_t           ctl_reg;
    logic [W-2:0]        t_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                lo_reg[ax]  <= (t_a[ax] < t_b[ax]) ? t_a[ax] : t_b[ax];
                hi_reg[ax]  <= (t_a[ax] < t_b[ax]) ? t_b[ax] : t_a[ax];
                dna_reg[ax] <= dir_neg[ax];
            end
        end
    end

    always_comb
    begin
        tmin_next = lo_reg[0];
        tmax_next = hi_reg[0];
        for (int ax = 1; ax < 3; ax++)
        begin
            if (lo_reg[ax] > tmin_next)
                tmin_next = lo_reg[ax];
            if (hi_reg[ax] < tmax_next)
                tmax_next = hi_reg[ax];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
            near_reg <= lo_reg;
            dnb_reg  <= dna_reg;
        end
    end

    // The hit time is the exit when the ray starts inside the box.
    always_comb
    begin
        logic signed [W-1:0] tt;
        logic                miss;
        tt       = (tmin_reg < 0) ? tmax_reg : tmin_reg;
        miss     = (tmax_reg < 0) || (tmin_reg > tmax_reg) || (tt <= 0);
        ctl_next = '0;
        t_next   = '0;
        if (!miss)
        begin
            ctl_next.hit = 1'b1;
            t_next       = tt[W-2:0];
            if (tmin_reg == near_reg[0])
            begin
                ctl_next.normal_axis     = AXIS_X;
                ctl_next.normal_positive = dnb_reg[0];
            end
            else if (tmin_reg == near_reg[1])
            begin
                ctl_next.normal_axis     = AXIS_Y;
                ctl_next.normal_positive = dnb_reg[1];
            end
            else if (tmin_reg == near_reg[2])
            begin
                ctl_next.normal_axis     = AXIS_Z;
                ctl_next.normal_positive = dnb_reg[2];
            end
            else
            begin
                ctl_next.normal_axis = AXIS_NONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= ctl_next;
            t_reg   <= t_next;
        end
    end

    assign ctl   = ctl_reg;
    assign t_hit = t_reg;

endmodule

>>> hw/rtl/rast_hitpos.sv
// Hit point: direction times t, then saturated add to the origin; holds the output register.
// Depends on rast_pkg; instantiated by the top level.
`timescale 1ns / 1ps

module rast_hitpos #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  rast_pkg::rast_ctl_t           ctl,
    input  logic [COORD_WIDTH-2:0]        t_hit,
    input  logic signed [COORD_WIDTH-1:0] org [3],
    input  logic signed [COORD_WIDTH-1:0] dir [3],
    output logic                          hit,
    output logic [COORD_WIDTH-2:0]        hit_time,
    output logic signed [COORD_WIDTH-1:0] hit_pos [3],
    output logic [1:0]                    normal_axis,
    output logic                          normal_positive
);
    import rast_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W - 1;
    localparam int SW = 2 * W + 1;

    logic [PW-1:0]       prod_reg [3];
    logic signed [W-1:0] o_reg    [3];
    logic                dn_reg   [3];
    rast_ctl_t           ctl_reg;
    logic [W-2:0]        t_reg;

    logic [W-1:0]        mag [3];

    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
            mag[ax] = dir[ax][W-1] ? (~dir[ax] + 1'b1) : dir[ax];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                prod_reg[ax] <= PW'(mag[ax]) * PW'(t_hit);
                o_reg[ax]    <= org[ax];
                dn_reg[ax]   <= dir[ax][W-1];
            end
            ctl_reg <= ctl;
            t_reg   <= t_hit;
        end
    end

    logic signed [SW-1:0] pmax;
    logic signed [SW-1:0] pmin;
    logic signed [W-1:0]  pos_next [3];

    assign pmax = {{(W+2){1'b0}}, {(W-1){1'b1}}};
    assign pmin = {{(W+2){1'b1}}, {(W-1){1'b0}}};

    always_comb
    begin
        logic signed [SW-1:0] o_ext;
        logic signed [SW-1:0] m_ext;
        logic signed [SW-1:0] p;
        for (int ax = 0; ax < 3; ax++)
        begin
            o_ext = {{(W+1){o_reg[ax][W-1]}}, o_reg[ax]};
            m_ext = $signed({2'b00, prod_reg[ax] >> FRAC_BITS});
            p     = dn_reg[ax] ? (o_ext - m_ext) : (o_ext + m_ext);
            if (p > pmax)
                pos_next[ax] = pmax[W-1:0];
            else if (p < pmin)
                pos_next[ax] = pmin[W-1:0];
            else
                pos_next[ax] = p[W-1:0];
        end
    end

    // A miss clears every result field.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit             <= ctl_reg.hit;
            hit_time        <= ctl_reg.hit ? t_reg : '0;
            normal_axis     <= ctl_reg.hit ? ctl_reg.normal_axis : AXIS_NONE;
            normal_positive <= ctl_reg.hit & ctl_reg.normal_positive;
            for (int ax = 0; ax < 3; ax++)
                hit_pos[ax] <= ctl_reg.hit ? pos_next[ax] : '0;
        end
    end

endmodule

>>> tb/tb_ray_aabb_slab_test_core.sv
// Self-checking testbench for ray_aabb_slab_test_core: directed and random rays
// against padded boxes, checked against an in-bench slab predictor.
// Depends on rast_pkg and the ray_aabb_slab_test_core RTL.
`timescale 1ns / 1ps

module tb_ray_aabb_slab_test_core;
    import rast_pkg::*;

    localparam longint TMAX  = 64'sd2147483647;
    localparam longint SMIN  = -64'sd2147483648;
    localparam int     LIMIT = 400000;

    // One input item: ray origin, direction, box center and full box size per axis.
    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [2:0][31:0] ctr;
        logic [2:0][30:0] sz;
    } ray_item_t;

    // One result item as the block should present it.
    typedef struct packed {
        logic        hit;
        logic [30:0] t;
        logic [2:0][31:0] pos;
        logic [1:0]  axis;
        logic        npos;
    } hit_rec_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [30:0] hit_time;
    logic signed [31:0] hit_pos_x;
    logic signed [31:0] hit_pos_y;
    logic signed [31:0] hit_pos_z;
    logic [1:0]  normal_axis;
    logic        normal_positive;

    ray_item_t   cur_ray;
    ray_item_t   ray_queue[$];
    hit_rec_t    hit_queue[$];
    logic [30:0] pad_copy[3];

    int  err_count;
    int  cycle_count;
    int  burst_left;
    int  gap_left;
    bit  hold_rays;
    bit  in_taken;

    ray_aabb_slab_test_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .origin_x       (cur_ray.org[0]),
        .origin_y       (cur_ray.org[1]),
        .origin_z       (cur_ray.org[2]),
        .dir_x          (cur_ray.dir[0]),
        .dir_y          (cur_ray.dir[1]),
        .dir_z          (cur_ray.dir[2]),
        .box_center_x   (cur_ray.ctr[0]),
        .box_center_y   (cur_ray.ctr[1]),
        .box_center_z   (cur_ray.ctr[2]),
        .box_size_x     (cur_ray.sz[0]),
        .box_size_y     (cur_ray.sz[1]),
        .box_size_z     (cur_ray.sz[2]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .hit_time       (hit_time),
        .hit_pos_x      (hit_pos_x),
        .hit_pos_y      (hit_pos_y),
        .hit_pos_z      (hit_pos_z),
        .normal_axis    (normal_axis),
        .normal_positive(normal_positive)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Slab crossing parameter num * 2^16 / dir2, truncated toward zero and saturated.
    // A zero direction gives +-TMAX, or 0 when the numerator is also zero.
    function automatic longint slab_cross(longint num, longint dir2);
        longint a;
        longint b;
        longint q;
        if (dir2 == 0)
        begin
            return (num > 0) ? TMAX : ((num < 0) ? -TMAX : 64'sd0);
        end
        a = (num < 0) ? -num : num;
        b = (dir2 < 0) ? -dir2 : dir2;
        q = (a << 16) / b;
        if (q > TMAX)
        begin
            q = TMAX;
        end
        return ((num < 0) != (dir2 < 0)) ? -q : q;
    endfunction

    // Expected result for one ray under the current padding.
    function automatic hit_rec_t predict_hit(ray_item_t r);
        hit_rec_t res;
        longint o[3];
        longint dv[3];
        longint near_t[3];
        longint c;
        longint e;
        longint d;
        longint t1;
        longint t2;
        longint lo;
        longint hi;
        longint t_in;
        longint t_out;
        longint t;
        longint m;
        longint p;
        res = '0;
        t_in = 0;
        t_out = 0;
        for (int ax = 0; ax < 3; ax++)
        begin
            o[ax]  = longint'($signed(r.org[ax]));
            dv[ax] = longint'($signed(r.dir[ax]));
            c      = longint'($signed(r.ctr[ax]));
            e      = longint'({33'd0, r.sz[ax]}) + 2 * longint'({33'd0, pad_copy[ax]});
            d      = 2 * (c - o[ax]);
            t1     = slab_cross(d - e, 2 * dv[ax]);
            t2     = slab_cross(d + e, 2 * dv[ax]);
            lo     = (t1 < t2) ? t1 : t2;
            hi     = (t1 < t2) ? t2 : t1;
            near_t[ax] = lo;
            if (ax == 0 || lo > t_in)
            begin
                t_in = lo;
            end
            if (ax == 0 || hi < t_out)
            begin
                t_out = hi;
            end
        end
        if (t_out < 0 || t_in > t_out)
        begin
            return res;
        end
        t = (t_in < 0) ? t_out : t_in;
        if (t <= 0)
        begin
            return res;
        end
        res.hit = 1'b1;
        res.t   = t[30:0];
        for (int ax = 0; ax < 3; ax++)
        begin
            m = (((dv[ax] < 0) ? -dv[ax] : dv[ax]) * t) >>> 16;
            p = (dv[ax] < 0) ? o[ax] - m : o[ax] + m;
            if (p > TMAX)
            begin
                p = TMAX;
            end
            if (p < SMIN)
            begin
                p = SMIN;
            end
            res.pos[ax] = p[31:0];
        end
        for (int ax = 2; ax >= 0; ax--)
        begin
            // Walking backward leaves the first matching axis, so x wins ties.
            if (t_in == near_t[ax])
            begin
                res.axis = logic'(ax == 0) ? AXIS_X : ((ax == 1) ? AXIS_Y : AXIS_Z);
                res.npos = dv[ax] < 0;
            end
        end
        return res;
    endfunction

    // Sampling side: record input acceptance, predict, check results, watch the clock limit.
    always @(posedge clk)
    begin
        hit_rec_t want;
        hit_rec_t got;
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("FAIL ray_aabb_slab_test_core");
            $finish;
        end
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
        begin
            hit_queue.push_back(predict_hit(cur_ray));
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = '{hit, hit_time, {hit_pos_z, hit_pos_y, hit_pos_x},
                    normal_axis, normal_positive};
            if (hit_queue.size() == 0)
            begin
                $display("%0t: result item with none expected: %h", $realtime, got);
                err_count = err_count + 1;
            end
            else
            begin
                want = hit_queue.pop_front();
                if (got.hit !== want.hit)
                begin
                    $display("%0t: hit exp %h act %h", $realtime, want.hit, got.hit);
                    err_count = err_count + 1;
                end
                if (got.t !== want.t)
                begin
                    $display("%0t: hit_time exp %h act %h", $realtime, want.t, got.t);
                    err_count = err_count + 1;
                end
                for (int ax = 0; ax < 3; ax++)
                begin
                    if (got.pos[ax] !== want.pos[ax])
                    begin
                        $display("%0t: hit_pos[%0d] exp %h act %h", $realtime, ax,
                                 want.pos[ax], got.pos[ax]);
                        err_count = err_count + 1;
                    end
                end
                if (got.axis !== want.axis)
                begin
                    $display("%0t: normal_axis exp %h act %h", $realtime, want.axis, got.axis);
                    err_count = err_count + 1;
                end
                if (got.npos !== want.npos)
                begin
                    $display("%0t: normal_positive exp %h act %h", $realtime,
                             want.npos, got.npos);
                    err_count = err_count + 1;
                end
            end
        end
    end

    // Sender: feeds rays from the queue in bursts of random length with random gaps.
    // A presented item is held until the rising edge that takes it.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (!hold_rays && ray_queue.size() > 0)
            begin
                cur_ray <= ray_queue.pop_front();
                in_valid <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random, except for stretches where it always takes the item.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if ((cycle_count / 700) % 3 == 0)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) < ((cycle_count / 700) % 3 == 1 ? 70 : 35));
        end
    end

    // Writes one padding register and reads it back.
    task automatic write_pad(input logic [1:0] idx, input logic [30:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {1'b0, val};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata[30:0] !== val)
        begin
            $display("%0t: pad read %0d exp %h act %h", $realtime, idx, val, prdata);
            err_count = err_count + 1;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pad_copy[idx] = val;
    endtask

    task automatic set_pads(input logic [30:0] px, input logic [30:0] py,
                            input logic [30:0] pz);
        write_pad(REG_PAD_X, px);
        write_pad(REG_PAD_Y, py);
        write_pad(REG_PAD_Z, pz);
    endtask

    // Waits until every queued ray is taken and every result is back, then
    // lets the pipeline drain.
    task automatic drain;
        while (ray_queue.size() > 0 || in_valid || hit_queue.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    // Mostly aimed rays with modest coordinates so that hits, insides and
    // grazes are common; the rest is full-range noise or wide-range rays with many zero directions.
    task automatic queue_random(input int count);
        ray_item_t r;
        int kind;
        int sh;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 9);
            for (int ax = 0; ax < 3; ax++)
            begin
                if (kind < 6)
                begin
                    r.ctr[ax] = $signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000;
                    r.sz[ax]  = 31'($urandom_range(0, 32'h001F_FFFF));
                    r.org[ax] = r.ctr[ax] + $signed($urandom_range(0, 32'h00FF_FFFF))
                                - 32'sh0080_0000;
                    sh = $urandom_range(0, 6);
                    r.dir[ax] = ($signed(r.ctr[ax] - r.org[ax]) >>> sh)
                                + $signed($urandom_range(0, 32'h3FFF)) - 32'sh2000;
                    if ($urandom_range(0, 15) == 0)
                    begin
                        r.dir[ax] = '0;
                    end
                end
                else if (kind < 9)
                begin
                    r.ctr[ax] = $urandom;
                    r.org[ax] = $urandom;
                    r.dir[ax] = $urandom;
                    r.sz[ax]  = 31'($urandom);
                end
                else
                begin
                    r.ctr[ax] = $urandom >> $urandom_range(0, 31);
                    r.org[ax] = -($urandom >> $urandom_range(0, 31));
                    r.dir[ax] = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
                    r.sz[ax]  = 31'($urandom >> $urandom_range(0, 30));
                end
            end
            ray_queue.push_back(r);
        end
    endtask

    task automatic queue_directed;
        ray_item_t r;
        // All fields zero: zero directions, with zero numerators under zero padding.
        r = '0;
        ray_queue.push_back(r);
        // All fields at their maximum, then signed fields at their minimum.
        r = '1;
        r.org = {3{32'h7FFF_FFFF}};
        r.dir = {3{32'h7FFF_FFFF}};
        r.ctr = {3{32'h7FFF_FFFF}};
        ray_queue.push_back(r);
        r.org = {3{32'h8000_0000}};
        r.dir = {3{32'h8000_0000}};
        r.ctr = {3{32'h8000_0000}};
        ray_queue.push_back(r);
        // Origin far negative, box far positive: slab times saturate.
        r.org = {3{32'h8000_0000}};
        r.ctr = {3{32'h7FFF_FFFF}};
        r.dir = {3{32'h0000_0001}};
        r.sz  = {3{31'h0001_0000}};
        ray_queue.push_back(r);
        // Ray along x only, others zero direction, hitting from -x.
        r = '0;
        r.org[0] = -32'sh0005_0000;
        r.dir[0] = 32'h0001_0000;
        r.sz  = {3{31'h0002_0000}};
        ray_queue.push_back(r);
        // Same from +x: positive normal.
        r.org[0] = 32'h0005_0000;
        r.dir[0] = -32'sh0001_0000;
        ray_queue.push_back(r);
        // Along y and along z.
        r = '0;
        r.org[1] = 32'h0005_0000;
        r.dir[1] = -32'sh0000_8000;
        r.sz  = {3{31'h0002_0000}};
        ray_queue.push_back(r);
        r = '0;
        r.org[2] = -32'sh0005_0000;
        r.dir[2] = 32'h0003_0000;
        r.sz  = {3{31'h0002_0000}};
        ray_queue.push_back(r);
        // Diagonal, equal entries on all axes: tie goes to x.
        r = '0;
        r.org = {3{-32'sh0004_0000}};
        r.dir = {3{32'h0001_0000}};
        r.sz  = {3{31'h0002_0000}};
        ray_queue.push_back(r);
        // Tie between y and z only.
        r.org[0] = '0;
        r.dir[0] = 32'h0000_0100;
        ray_queue.push_back(r);
        // Origin inside the box: entry negative, exit chosen.
        r = '0;
        r.dir = {32'h0000_3000, -32'sh0001_0000, 32'h0002_0000};
        r.sz  = {3{31'h0004_0000}};
        ray_queue.push_back(r);
        // Box behind the ray: exit negative.
        r = '0;
        r.org[0] = 32'h0005_0000;
        r.dir[0] = 32'h0001_0000;
        r.sz  = {3{31'h0002_0000}};
        ray_queue.push_back(r);
        // Slabs that do not overlap: entry beyond exit.
        r = '0;
        r.org = {3{-32'sh0004_0000}};
        r.ctr = {32'h0000_0000, 32'h0000_0000, 32'h0008_0000};
        r.dir = {32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        r.sz  = {3{31'h0001_0000}};
        ray_queue.push_back(r);
        // Zero-size box touched exactly: the x entry equals the x exit.
        r = '0;
        r.org[0] = -32'sh0002_0000;
        r.dir[0] = 32'h0001_0000;
        ray_queue.push_back(r);
        // Zero direction with the origin outside a slab: miss.
        r = '0;
        r.org[1] = 32'h0009_0000;
        r.dir[0] = 32'h0001_0000;
        r.org[0] = -32'sh0005_0000;
        r.sz  = {3{31'h0002_0000}};
        ray_queue.push_back(r);
        // Origin on the far face: chosen t is zero, a miss.
        r = '0;
        r.org[0] = 32'h0001_0000;
        r.dir[0] = 32'h0001_0000;
        r.sz  = {3{31'h0002_0000}};
        ray_queue.push_back(r);
        // Tiny direction: most slab times saturate at +-TMAX.
        r = '0;
        r.org[0] = -32'sh4000_0000;
        r.dir = {32'h0000_0001, 32'h0000_0001, 32'h0000_0001};
        r.sz  = {3{31'h7FFF_FFFF}};
        ray_queue.push_back(r);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        cur_ray     = '0;
        err_count   = 0;
        cycle_count = 0;
        burst_left  = 1;
        gap_left    = 0;
        hold_rays   = 1'b0;
        in_taken    = 1'b0;
        pad_copy[0] = '0;
        pad_copy[1] = '0;
        pad_copy[2] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset padding first, with the directed rays.
        queue_directed();
        queue_random(200);
        // Part way through, hold the sender until every result is back.
        while (ray_queue.size() > 100)
        begin
            @(posedge clk);
        end
        hold_rays = 1'b1;
        while (in_valid || hit_queue.size() > 0)
        begin
            @(posedge clk);
        end
        hold_rays = 1'b0;
        drain();

        set_pads(31'($urandom_range(0, 32'h000F_FFFF)), 31'($urandom_range(0, 32'h000F_FFFF)),
                 31'($urandom_range(0, 32'h000F_FFFF)));
        queue_directed();
        queue_random(220);
        drain();

        set_pads(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        queue_random(150);
        drain();

        set_pads(31'($urandom), 31'($urandom), 31'($urandom));
        queue_random(150);
        drain();

        set_pads(31'h0000_0001, 31'h0, 31'h0001_0000);
        queue_random(200);
        drain();

        if (err_count == 0)
        begin
            $display("PASS ray_aabb_slab_test_core");
        end
        else
        begin
            $display("FAIL ray_aabb_slab_test_core");
        end
        $finish;
    end

endmodule

>>> ray_aabb_slab_test_core.f
hw/rtl/rast_pkg.sv
hw/rtl/rast_slab_div.sv
hw/rtl/rast_select.sv
hw/rtl/rast_hitpos.sv
hw/rtl/ray_aabb_slab_test_core.sv
tb/tb_ray_aabb_slab_test_core.sv
